FILE: hw/rtl/swsax_pkg.sv
// ----------------------------------------------------------------------------
// swsax_pkg
// Shared types and constants of the sliding window SAX encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swsax_pkg;

   localparam int MAX_WINDOW   = 1024;
   localparam int MAX_SEGMENTS = 15;
   localparam int SAMPLE_BITS  = 16;
   localparam int ADDR_W       = $clog2(MAX_WINDOW);
   localparam int CFG_W        = 11;
   localparam int SEG_W        = 4;
   localparam int WORD_W       = 30;
   localparam int SUM_W        = 27;
   localparam int SQ_W         = 41;
   localparam int VAR_W        = 51;
   localparam int PROD_W       = 39;
   localparam int MAG_W        = 38;
   localparam int MB_W         = 45;
   localparam int ACC_W        = 90;

   localparam logic [1:0] REG_WINDOW_LEN    = 2'd0;
   localparam logic [1:0] REG_SEGMENT_WIDTH = 2'd1;
   localparam logic [1:0] REG_WORD_LEN      = 2'd2;

   localparam logic [1:0] SYM_LOW  = 2'd0;
   localparam logic [1:0] SYM_MLOW = 2'd1;
   localparam logic [1:0] SYM_MHI  = 2'd2;
   localparam logic [1:0] SYM_HIGH = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_VNQ,
      ST_VSS,
      ST_VSUB,
      ST_SYM_CNT,
      ST_SYM_NUM,
      ST_SYM_L,
      ST_SYM_R,
      ST_SYM_CMP,
      ST_DECIDE,
      ST_MUL
   } state_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sliding_window_sax_encoder_core.sv
// ----------------------------------------------------------------------------
// sliding_window_sax_encoder_core
// Windowed z-normalised SAX encoder, four-symbol alphabet.
// ----------------------------------------------------------------------------
// Requests (req_sample, req_first_of_series) enter on a valid/ready channel;
// req_first_of_series starts a new series. Words leave on the rsp_ channel
// with the series number and window start, only when the word changes.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, since the block itself does not enforce this.
// One request is worked on at a time; req_ready is low until it is done.
// A request that does not fill the window is stored and the block stays idle.
// Otherwise the delay-line memory is swept once, then the variance and each
// symbol go through one shared shift-add multiplier, one bit a cycle.
// Output is held in a register; a stalled receiver holds a finished word
// and the block stalls only when the next word is ready too.
// Reset clears all control state and restores the register defaults.
// The delay line needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_sax_encoder_core (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_valid,
   output logic                                       req_ready,
   input  wire signed [swsax_pkg::SAMPLE_BITS-1:0]    req_sample,
   input  wire                                        req_first_of_series,
   output logic                                       rsp_valid,
   input  wire                                        rsp_ready,
   output logic [swsax_pkg::WORD_W-1:0]               rsp_sax_word,
   output logic [15:0]                                rsp_series_number,
   output logic [15:0]                                rsp_window_start,
   input  wire                                        csr_we,
   input  wire  [1:0]                                 csr_index,
   input  wire  [swsax_pkg::CFG_W-1:0]                csr_wdata
);
   import swsax_pkg::*;

   state_type state_ff, state_in, ret_ff;

   logic [CFG_W-1:0] win_len_ff, seg_wid_ff;
   logic [SEG_W-1:0] word_len_ff;
   logic [CFG_W-1:0] n, w;
   logic [SEG_W-1:0] segs;

   logic signed [SAMPLE_BITS-1:0] win_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_valid_ff;
   logic [ADDR_W-1:0]             wp_ff, rd_addr;

   logic [15:0] seen_ff, series_ff, seen_base, seen_new;
   logic        sat_ff, sat_new, full, accept;

   logic [CFG_W-1:0]        p_ff, pos_ff;
   logic [SEG_W-1:0]        k_ff, sym_k_ff;
   logic signed [SUM_W-1:0] s_ff;
   logic [SQ_W-1:0]         q_ff;
   logic signed [SUM_W-1:0] seg_sum_ff [MAX_SEGMENTS];
   logic [CFG_W-1:0]        seg_cnt_ff [MAX_SEGMENTS];
   logic signed [31:0]      sq;

   logic [VAR_W-1:0]         nq_ff, v_ff;
   logic [ACC_W-1:0]         mul_a_ff, acc_ff, l_ff;
   logic [MB_W-1:0]          mul_b_ff;
   logic signed [PROD_W-1:0] prod_ff, num_ff, n_s, cnt_s, ss_x, s_x;
   logic [CFG_W-1:0]         cnt_ff, cnt_cur;
   logic signed [SUM_W-1:0]  ss_cur;
   logic [17:0]              y_ff;
   logic [35:0]              y_sq;
   logic [MAG_W-1:0]         mag;
   logic [MB_W-1:0]          m_val;
   logic [SUM_W-1:0]         abs_s;
   logic                     neg_ff, sym_last, shortcut, skip, can_load;
   logic [1:0]               sym_val, short_sym;
   logic [WORD_W-1:0]        word_ff, prev_word_ff;
   logic                     prev_valid_ff;

   // clamped configuration
   always_comb begin
      n = win_len_ff;
      if (win_len_ff < CFG_W'(2)) n = CFG_W'(2);
      if (win_len_ff > CFG_W'(MAX_WINDOW)) n = CFG_W'(MAX_WINDOW);
      w = (seg_wid_ff == '0) ? CFG_W'(1) : seg_wid_ff;
      segs = word_len_ff;
      if (word_len_ff == '0) segs = SEG_W'(1);
      if (word_len_ff > SEG_W'(MAX_SEGMENTS)) segs = SEG_W'(MAX_SEGMENTS);
   end

   assign accept    = req_valid && req_ready;
   assign seen_base = req_first_of_series ? 16'd0 : seen_ff;
   assign sat_new   = (seen_base == 16'hFFFF);
   assign seen_new  = sat_new ? seen_base : seen_base + 16'd1;
   assign full      = seen_new >= {5'd0, n};

   assign rd_addr = wp_ff - n[ADDR_W-1:0] + p_ff[ADDR_W-1:0];
   assign sq      = rd_data_ff * rd_data_ff;

   assign ss_cur  = seg_sum_ff[sym_k_ff];
   assign cnt_cur = seg_cnt_ff[sym_k_ff];
   assign ss_x    = PROD_W'(ss_cur);
   assign s_x     = PROD_W'(s_ff);
   assign n_s     = signed'({{(PROD_W-CFG_W){1'b0}}, n});
   assign cnt_s   = signed'({{(PROD_W-CFG_W){1'b0}}, cnt_ff});
   assign abs_s   = s_ff[SUM_W-1] ? SUM_W'(-s_ff) : SUM_W'(s_ff);
   assign mag     = num_ff[PROD_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   assign m_val   = MB_W'(mag) * MB_W'(100);
   assign y_sq    = 36'(y_ff) * 36'(y_ff);

   assign sym_last  = (sym_k_ff == segs - SEG_W'(1));
   assign shortcut  = (v_ff == '0) || (cnt_cur == '0);
   assign short_sym = (v_ff == '0) ? SYM_HIGH : SYM_MHI;
   assign skip      = prev_valid_ff && (word_ff == prev_word_ff);
   assign can_load  = !rsp_valid || rsp_ready;

   always_comb begin
      if (neg_ff) sym_val = (l_ff > acc_ff) ? SYM_LOW : SYM_MLOW;
      else        sym_val = (l_ff >= acc_ff) ? SYM_HIGH : SYM_MHI;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid && full) state_in = ST_SWEEP;
         ST_SWEEP:   if (p_ff == n - CFG_W'(1)) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_VNQ;
         ST_VNQ:     state_in = ST_MUL;
         ST_VSS:     state_in = ST_MUL;
         ST_VSUB:    state_in = ST_SYM_CNT;
         ST_SYM_CNT: begin
            if (!shortcut) state_in = ST_SYM_NUM;
            else if (sym_last) state_in = ST_DECIDE;
         end
         ST_SYM_NUM: state_in = ST_SYM_L;
         ST_SYM_L:   state_in = ST_MUL;
         ST_SYM_R:   state_in = ST_MUL;
         ST_SYM_CMP: state_in = sym_last ? ST_DECIDE : ST_SYM_CNT;
         ST_DECIDE:  if (skip || can_load) state_in = ST_IDLE;
         ST_MUL:     if (mul_b_ff == '0) state_in = ret_ff;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff  <= CFG_W'(15);
         seg_wid_ff  <= CFG_W'(1);
         word_len_ff <= SEG_W'(15);
      end else if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LEN:    win_len_ff  <= csr_wdata;
            REG_SEGMENT_WIDTH: seg_wid_ff  <= csr_wdata;
            REG_WORD_LEN:      word_len_ff <= csr_wdata[SEG_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) win_mem[wp_ff] <= req_sample;
      rd_data_ff <= win_mem[rd_addr];
   end

   // control and series state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         seen_ff       <= '0;
         series_ff     <= '0;
         sat_ff        <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_word_ff  <= '0;
         rsp_valid     <= 1'b0;
         rd_valid_ff   <= 1'b0;
         ret_ff        <= ST_IDLE;
      end else begin
         rd_valid_ff <= (state_ff == ST_SWEEP);
         if (accept) begin
            wp_ff   <= wp_ff + ADDR_W'(1);
            seen_ff <= seen_new;
            sat_ff  <= sat_new;
            if (req_first_of_series) begin
               series_ff     <= series_ff + 16'd1;
               prev_valid_ff <= 1'b0;
               prev_word_ff  <= '0;
            end
         end
         case (state_ff)
            ST_VNQ:   ret_ff <= ST_VSS;
            ST_VSS:   ret_ff <= ST_VSUB;
            ST_SYM_L: ret_ff <= ST_SYM_R;
            ST_SYM_R: ret_ff <= ST_SYM_CMP;
            default:  ;
         endcase
         if (state_ff == ST_DECIDE && !skip && can_load) begin
            prev_valid_ff <= 1'b1;
            prev_word_ff  <= word_ff;
            rsp_valid     <= 1'b1;
         end else if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff     <= '0;
         pos_ff   <= '0;
         k_ff     <= '0;
         sym_k_ff <= '0;
         s_ff     <= '0;
         q_ff     <= '0;
         word_ff  <= '0;
         for (int i = 0; i < MAX_SEGMENTS; i++) begin
            seg_sum_ff[i] <= '0;
            seg_cnt_ff[i] <= '0;
         end
      end
      if (state_ff == ST_SWEEP) p_ff <= p_ff + CFG_W'(1);
      if (rd_valid_ff) begin
         s_ff             <= s_ff + SUM_W'(rd_data_ff);
         q_ff             <= q_ff + SQ_W'(unsigned'(sq));
         seg_sum_ff[k_ff] <= seg_sum_ff[k_ff] + SUM_W'(rd_data_ff);
         seg_cnt_ff[k_ff] <= seg_cnt_ff[k_ff] + CFG_W'(1);
         if (pos_ff == w - CFG_W'(1) && k_ff != segs - SEG_W'(1)) begin
            k_ff   <= k_ff + SEG_W'(1);
            pos_ff <= '0;
         end else begin
            pos_ff <= pos_ff + CFG_W'(1);
         end
      end
      case (state_ff)
         ST_VNQ: begin
            mul_a_ff <= ACC_W'(q_ff);
            mul_b_ff <= MB_W'(n);
            acc_ff   <= '0;
         end
         ST_VSS: begin
            nq_ff    <= acc_ff[VAR_W-1:0];
            mul_a_ff <= ACC_W'(abs_s);
            mul_b_ff <= MB_W'(abs_s);
            acc_ff   <= '0;
         end
         ST_VSUB: v_ff <= nq_ff - acc_ff[VAR_W-1:0];
         ST_SYM_CNT: begin
            prod_ff <= ss_x * n_s;
            cnt_ff  <= cnt_cur;
            if (shortcut) begin
               word_ff  <= {word_ff[WORD_W-3:0], short_sym};
               sym_k_ff <= sym_k_ff + SEG_W'(1);
            end
         end
         ST_SYM_NUM: num_ff <= prod_ff - s_x * cnt_s;
         ST_SYM_L: begin
            neg_ff   <= num_ff[PROD_W-1];
            mul_a_ff <= ACC_W'(m_val);
            mul_b_ff <= m_val;
            acc_ff   <= '0;
            y_ff     <= 18'(cnt_ff) * 18'd67;
         end
         ST_SYM_R: begin
            l_ff     <= acc_ff;
            mul_a_ff <= ACC_W'(v_ff);
            mul_b_ff <= MB_W'(y_sq);
            acc_ff   <= '0;
         end
         ST_SYM_CMP: begin
            word_ff  <= {word_ff[WORD_W-3:0], sym_val};
            sym_k_ff <= sym_k_ff + SEG_W'(1);
         end
         ST_DECIDE: begin
            if (!skip && can_load) begin
               rsp_sax_word      <= word_ff;
               rsp_series_number <= series_ff - 16'd1;
               rsp_window_start  <= sat_ff ? 16'hFFFF : seen_ff - 16'(n);
            end
         end
         ST_MUL: begin
            if (mul_b_ff != '0) begin
               if (mul_b_ff[0]) acc_ff <= acc_ff + mul_a_ff;
               mul_a_ff <= mul_a_ff << 1;
               mul_b_ff <= mul_b_ff >> 1;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_sweep_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> p_ff < n)
      else $error("sweep index beyond window");
   a_symbol_in_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SYM_CMP |-> sym_k_ff < segs)
      else $error("symbol index beyond word");
   a_word_recorded: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> prev_valid_ff && prev_word_ff == rsp_sax_word)
      else $error("emitted word not recorded as previous");
   a_busy_after_sweep: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |=> !req_ready)
      else $error("ready during word computation");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding window SAX encoder core.
// ----------------------------------------------------------------------------
// Drives sample requests through several configurations: short directed runs,
// then random series with random sample styles. A scoreboard predicts each
// word from its own copy of the delay line and compares every response field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import swsax_pkg::*;

   localparam int HOLD_OFF   = 600;
   localparam int SETTLE     = 3000;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [15:0]       series;
      logic [15:0]       start;
   } sax_result_type;

   class sax_scoreboard_type;
      int unsigned  win_len, seg_w, word_n;
      longint       line [MAX_WINDOW];
      int unsigned  seen;
      logic [15:0]  series;
      logic [WORD_W-1:0] last_word;
      bit           last_ok;
      sax_result_type pending [$];
      int           errors;

      function new();
         win_len = 15; seg_w = 1; word_n = 15;
         foreach (line[i]) line[i] = 0;
         seen = 0; series = 0; last_word = 0; last_ok = 0; errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            REG_WINDOW_LEN:    win_len = 32'(val);
            REG_SEGMENT_WIDTH: seg_w = 32'(val);
            REG_WORD_LEN:      word_n = 32'(val[SEG_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_request(logic signed [SAMPLE_BITS-1:0] smp, logic first);
         int unsigned n, w, segs, lo, hi, cnt;
         longint s, q, v, ss, num;
         longint unsigned mag, y;
         logic [127:0] lhs, rhs;
         logic [1:0] sym;
         logic [WORD_W-1:0] word;
         bit sat;
         sax_result_type r;
         if (first) begin
            series = series + 16'd1;
            seen = 0; last_ok = 0; last_word = 0;
         end
         for (int i = MAX_WINDOW - 1; i > 0; i--) line[i] = line[i-1];
         line[0] = smp;
         sat = (seen == 16'hFFFF);
         if (!sat) seen++;
         n = win_len < 2 ? 2 : (win_len > MAX_WINDOW ? MAX_WINDOW : win_len);
         w = seg_w == 0 ? 1 : seg_w;
         segs = word_n == 0 ? 1 : (word_n > MAX_SEGMENTS ? MAX_SEGMENTS : word_n);
         if (seen < n) return;
         s = 0; q = 0;
         for (int i = 0; i < n; i++) begin
            s += line[i];
            q += line[i] * line[i];
         end
         v = longint'(n) * q - s * s;
         word = '0;
         for (int k = 0; k < segs; k++) begin
            lo = k * w;
            if (lo > n) lo = n;
            hi = (k == segs - 1) ? n : (k + 1) * w;
            if (hi > n) hi = n;
            cnt = hi - lo;
            ss = 0;
            for (int p = lo; p < hi; p++) ss += line[n-1-p];
            if (v <= 0) sym = SYM_HIGH;
            else if (cnt == 0) sym = SYM_MHI;
            else begin
               num = ss * longint'(n) - s * longint'(cnt);
               mag = num < 0 ? -num : num;
               lhs = 128'(100 * mag) * 128'(100 * mag);
               y = 67 * cnt;
               rhs = 128'(y * y) * 128'(v);
               if (num < 0) sym = (lhs > rhs) ? SYM_LOW : SYM_MLOW;
               else sym = (lhs >= rhs) ? SYM_HIGH : SYM_MHI;
            end
            word = {word[WORD_W-3:0], sym};
         end
         if (last_ok && word == last_word) return;
         last_word = word; last_ok = 1;
         r.word = word;
         r.series = series - 16'd1;
         r.start = sat ? 16'hFFFF : 16'(seen - n);
         pending.insert(pending.size(), r);
      endfunction

      function void check_word(logic [WORD_W-1:0] word, logic [15:0] sn, logic [15:0] ws);
         sax_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected word %h series %0d start %0d", word, sn, ws);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (word !== e.word) begin
            $error("sax_word expected %h got %h", e.word, word); errors++;
         end
         if (sn !== e.series) begin
            $error("series_number expected %0d got %0d", e.series, sn); errors++;
         end
         if (ws !== e.start) begin
            $error("window_start expected %0d got %0d", e.start, ws); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic req_first_of_series = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [WORD_W-1:0] rsp_sax_word;
   logic [15:0] rsp_series_number, rsp_window_start;
   logic csr_we = 0;
   logic [1:0] csr_index = REG_WINDOW_LEN;
   logic [CFG_W-1:0] csr_wdata = '0;

   sax_scoreboard_type sb = new();
   int unsigned words_seen = 0;
   int unsigned quiet = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   sliding_window_sax_encoder_core dut (
      .clock, .reset, .req_valid, .req_ready, .req_sample, .req_first_of_series,
      .rsp_valid, .rsp_ready, .rsp_sax_word, .rsp_series_number, .rsp_window_start,
      .csr_we, .csr_index, .csr_wdata
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off to back the block up
   initial begin
      int unsigned stall;
      @(negedge reset);
      forever begin
         if (words_seen == 10) begin
            stall = HOLD_OFF;
         end else begin
            stall = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) stall = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_word(rsp_sax_word, rsp_series_number, rsp_window_start);
         words_seen++;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic configure(int unsigned wl, int unsigned sw, int unsigned wn);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_reg(REG_WINDOW_LEN, CFG_W'(wl));
      write_reg(REG_SEGMENT_WIDTH, CFG_W'(sw));
      write_reg(REG_WORD_LEN, CFG_W'(wn));
   endtask

   bit burst;

   task automatic send(logic signed [SAMPLE_BITS-1:0] smp, logic first);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1; req_sample <= smp; req_first_of_series <= first;
      do @(posedge clock); while (!req_ready);
      sb.note_request(smp, first);
   endtask

   task automatic random_run(int unsigned count, int unsigned max_len);
      int unsigned left, style;
      logic signed [SAMPLE_BITS-1:0] base, smp;
      left = 0; style = 0; base = 0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 49) == 0) burst = !burst;
         if (left == 0) begin
            left = $urandom_range(1, max_len);
            style = $urandom_range(0, 4);
            base = $signed(16'($urandom));
         end
         case (style)
            0: smp = $signed(16'($urandom));
            1: smp = base + $signed(16'($urandom_range(0, 8))) - 16'sd4;
            2: smp = (left % 7 == 0) ? base + 16'sd1 : base;
            3: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: smp = $signed(16'($urandom_range(0, 200))) - 16'sd100;
         endcase
         send(smp, (left == 1 && $urandom_range(0, 9) == 0) ? 1'b0 :
                   (i == 0 || left == 1) ? 1'b1 : 1'b0);
         left--;
      end
   endtask

   initial begin
      burst = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(REG_WINDOW_LEN, CFG_W'(4));
      write_reg(REG_SEGMENT_WIDTH, CFG_W'(1));
      write_reg(REG_WORD_LEN, CFG_W'(15));
      // samples ahead of any series start, extremes, then a flat series
      send(16'sh8000, 1'b0); send(16'sh7FFF, 1'b0); send(16'sh8000, 1'b0);
      send(16'sh7FFF, 1'b0); send(16'sd0, 1'b0); send(16'sd1, 1'b0);
      send(-16'sd1, 1'b0);
      send(16'sd7, 1'b1);
      repeat (5) send(16'sd7, 1'b0);
      send(16'sh8000, 1'b0); send(16'sh8000, 1'b0); send(16'sh7FFF, 1'b0);
      send(16'sd0, 1'b0); send(16'sd0, 1'b1);
      repeat (3) send(16'sh7FFF, 1'b0);
      send(16'sh8000, 1'b0);
      random_run(40, 20);

      configure(15, 1, 15);  random_run(30, 40);
      configure(2, 1, 1);    random_run(20, 12);
      configure(0, 0, 0);    random_run(15, 12);
      configure(8, 3, 3);    random_run(20, 30);
      configure(20, 7, 8);   random_run(25, 60);
      configure(6, 2047, 5); random_run(20, 20);
      // window clamped to the maximum, one series long enough to fill it
      configure(2047, 300, 15);
      for (int i = 0; i < 1030; i++) send($signed(16'($urandom)), i == 0);

      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
